// ===== hdl/assert_macros.svh =====
// Assertion macros for the near-duplicate row filter.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define NDRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define NDRF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/ndrf_pkg.sv =====
// Shared types and constants for the near-duplicate row filter.
// No dependencies; used by every module of the block.
package ndrf_pkg;

  localparam int unsigned MAX_UNIQUE_DEF = 64;
  localparam int unsigned DIMS_DEF       = 3;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NUM_COORD = 3;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned DIST_W = 2 * COORD_W;

  localparam logic [COORD_W-1:0] TOL_RESET = 32'd66;
  localparam logic [DIST_W-1:0]  TOL_SQ_RESET = 64'd4356;

  // Configuration register indexes.
  localparam logic REG_TOLERANCE = 1'b0;

  typedef logic [NUM_COORD-1:0][COORD_W-1:0] row_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

endpackage

// ===== hdl/ndrf_cell.sv =====
// One storage cell of the row ring: holds one stored row.
// Depends on ndrf_pkg for the row and control types.
module ndrf_cell (
  input  logic                clk_i,
  input  ndrf_pkg::cell_ctrl_t ctrl_i,
  input  ndrf_pkg::row_t      nbr_row_i,
  input  ndrf_pkg::row_t      load_row_i,
  output ndrf_pkg::row_t      row_o
);

  ndrf_pkg::row_t row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.load) begin
      row_d = load_row_i;
    end else if (ctrl_i.shift) begin
      row_d = nbr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o = row_q;

endmodule

// ===== hdl/ndrf_dist.sv =====
// Four-stage squared-distance unit: |a-b|, square, sum, compare with tolerance squared.
// Depends on ndrf_pkg for the row and result types.
module ndrf_dist #(
  parameter int unsigned DIMS = ndrf_pkg::DIMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_i,
  input  ndrf_pkg::row_t                      a_row_i,
  input  ndrf_pkg::row_t                      b_row_i,
  input  logic [ndrf_pkg::DIST_W-1:0]         tol_sq_i,
  output ndrf_pkg::dist_res_t                 res_o,
  output logic                                busy_o
);

  localparam int unsigned CW = ndrf_pkg::COORD_W;
  localparam int unsigned DW = ndrf_pkg::DIST_W;
  localparam int unsigned NC = ndrf_pkg::NUM_COORD;

  logic [NC-1:0][CW-1:0] abs_q, abs_d;
  logic [NC-1:0][DW-1:0] sq_q, sq_d;
  logic [DW+1:0]         sum_q, sum_d;
  logic                  hit_q, hit_d;
  logic                  v1_q, v2_q, v3_q, v4_q;

  // The difference of two 32-bit signed values needs 33 bits, but its
  // magnitude never exceeds 2^32-1 and so fits in 32 bits.
  always_comb begin
    logic signed [CW:0] diff;
    logic        [CW:0] mag;
    for (int k = 0; k < NC; k++) begin
      diff = $signed({a_row_i[k][CW-1], a_row_i[k]}) - $signed({b_row_i[k][CW-1], b_row_i[k]});
      mag = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
      abs_d[k] = (k < DIMS) ? mag[CW-1:0] : '0;
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sq_d[k] = DW'(abs_q[k]) * DW'(abs_q[k]);
    end
  end

  assign sum_d = (DW+2)'(sq_q[0]) + (DW+2)'(sq_q[1]) + (DW+2)'(sq_q[2]);

  // A sum past 2^64-1 sets one of the two upper bits and so can never lie below tolerance squared.
  assign hit_d = (sum_q[DW+1:DW] == 2'b00) && (sum_q[DW-1:0] < tol_sq_i);

  always_ff @(posedge clk_i) begin
    abs_q <= abs_d;
    sq_q  <= sq_d;
    sum_q <= sum_d;
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign res_o.valid = v4_q;
  assign res_o.hit   = hit_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q;

endmodule

// ===== hdl/near_duplicate_row_filter_core.sv =====
// Top level of the near-duplicate row filter: ring of row cells, distance unit, control.
// Depends on ndrf_pkg, ndrf_cell, ndrf_dist and assert_macros.svh.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------------
//  input   | in_valid_i/in_ready_o  | first_row_i, coord_0_i..coord_2_i
//  output  | out_valid_o/out_ready_i| row_is_new_o, table_overflow_o, out_coord_*_o,
//          |                        | unique_total_o
//  config  | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// A result appears once the stored rows have rotated once around the ring of cells past
// a single four-stage distance unit, one row per cycle, and that unit has drained (it has
// nothing to drain when the table is empty); a new request can be taken from the cycle in
// which the result appears.
// Reset empties the table and sets the tolerance to its default.
// A stalled output holds its result while the next request is already accepted.
module near_duplicate_row_filter_core #(
  parameter int unsigned MAX_UNIQUE = ndrf_pkg::MAX_UNIQUE_DEF,
  parameter int unsigned DIMS       = ndrf_pkg::DIMS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     first_row_i,
  input  logic signed [ndrf_pkg::COORD_W-1:0]      coord_0_i,
  input  logic signed [ndrf_pkg::COORD_W-1:0]      coord_1_i,
  input  logic signed [ndrf_pkg::COORD_W-1:0]      coord_2_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic                                     row_is_new_o,
  output logic                                     table_overflow_o,
  output logic signed [ndrf_pkg::COORD_W-1:0]      out_coord_0_o,
  output logic signed [ndrf_pkg::COORD_W-1:0]      out_coord_1_o,
  output logic signed [ndrf_pkg::COORD_W-1:0]      out_coord_2_o,
  output logic        [ndrf_pkg::TOTAL_W-1:0]      unique_total_o,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic        [2:0]                        paddr,
  input  logic        [31:0]                       pwdata,
  output logic        [31:0]                       prdata,
  output logic                                     pready
);

  localparam int unsigned CW    = ndrf_pkg::COORD_W;
  localparam int unsigned DW    = ndrf_pkg::DIST_W;
  localparam int unsigned CNT_W = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned STEP_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;

  ndrf_pkg::state_e state_q, state_d;

  logic [CW-1:0]     tol_q;
  logic [DW-1:0]     tol_sq_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              dup_q, dup_d;
  ndrf_pkg::row_t    row_q;
  logic              in_fire, out_free, store_row, scan_issue, tap_valid;
  logic [CNT_W-1:0]  tap_idx;

  logic              out_valid_q, out_new_q, out_ovf_q;
  ndrf_pkg::row_t    out_row_q;
  logic [CNT_W-1:0]  out_total_q;

  ndrf_pkg::row_t      ring [MAX_UNIQUE];
  ndrf_pkg::dist_res_t dist_res;
  logic                dist_busy;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ndrf_pkg::REG_TOLERANCE) ? tol_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= ndrf_pkg::TOL_RESET;
      tol_sq_q <= ndrf_pkg::TOL_SQ_RESET;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == ndrf_pkg::REG_TOLERANCE)) begin
        tol_q <= pwdata;
      end
      tol_sq_q <= DW'(tol_q) * DW'(tol_q);
    end
  end

  // The ring shifts one place per scan cycle, so after step j the last cell
  // shows stored entry MAX_UNIQUE-1-j; a full turn puts every row back home.
  assign tap_idx   = CNT_W'(MAX_UNIQUE - 1) - CNT_W'(step_q);
  assign tap_valid = tap_idx < count_q;
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign store_row = (state_q == ndrf_pkg::ST_FINISH) && out_free && !dup_q &&
                     (count_q < CNT_W'(MAX_UNIQUE));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    dup_d      = dup_q | (dist_res.valid & dist_res.hit);
    in_ready_o = 1'b0;
    scan_issue = 1'b0;
    unique case (state_q)
      ndrf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dup_d   = 1'b0;
          step_d  = '0;
          state_d = ndrf_pkg::ST_SCAN;
          if (first_row_i) begin
            count_d = '0;
          end
        end
      end
      ndrf_pkg::ST_SCAN: begin
        scan_issue = tap_valid;
        step_d     = step_q + STEP_W'(1);
        if (step_q == STEP_W'(MAX_UNIQUE - 1)) begin
          state_d = ndrf_pkg::ST_DRAIN;
        end
      end
      ndrf_pkg::ST_DRAIN: begin
        if (!dist_busy) begin
          state_d = ndrf_pkg::ST_FINISH;
        end
      end
      ndrf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = ndrf_pkg::ST_IDLE;
          if (store_row) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ndrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ndrf_pkg::ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      dup_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      dup_q   <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q <= {coord_2_i, coord_1_i, coord_0_i};
    end
  end

  // Ring of cells.
  for (genvar k = 0; k < MAX_UNIQUE; k++) begin : g_cell
    ndrf_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift = (state_q == ndrf_pkg::ST_SCAN);
    assign ctrl.load  = store_row && (count_q == CNT_W'(k));
    ndrf_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .nbr_row_i  (ring[(k + MAX_UNIQUE - 1) % MAX_UNIQUE]),
      .load_row_i (row_q),
      .row_o      (ring[k])
    );
  end

  ndrf_dist #(
    .DIMS (DIMS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (scan_issue),
    .a_row_i  (row_q),
    .b_row_i  (ring[MAX_UNIQUE-1]),
    .tol_sq_i (tol_sq_q),
    .res_o    (dist_res),
    .busy_o   (dist_busy)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ndrf_pkg::ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ndrf_pkg::ST_FINISH) && out_free) begin
      out_new_q   <= !dup_q;
      out_ovf_q   <= !dup_q && (count_q == CNT_W'(MAX_UNIQUE));
      out_row_q   <= row_q;
      out_total_q <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_is_new_o     = out_new_q;
  assign table_overflow_o = out_ovf_q;
  assign out_coord_0_o    = out_row_q[0];
  assign out_coord_1_o    = out_row_q[1];
  assign out_coord_2_o    = out_row_q[2];
  assign unique_total_o   = ndrf_pkg::TOTAL_W'(out_total_q);

  `include "assert_macros.svh"

  `NDRF_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_UNIQUE), "stored row count exceeds table size")
  `NDRF_ASSERT_NEVER(a_ready_while_busy, in_ready_o && dist_busy, "request taken during a scan")
  `NDRF_ASSERT(a_store_counts, store_row |=> (count_q == $past(count_q) + CNT_W'(1)), "stored row not counted")

endmodule
